@@ sv/diamond_line_warp_resampler_top_defines.svh @@
// Assertion macros for the diamond line warp resampler.
// Used by diamond_line_warp_resampler_top.sv; needs clock and reset in scope.
`ifndef DIAMOND_LINE_WARP_RESAMPLER_TOP_DEFINES_SVH
`define DIAMOND_LINE_WARP_RESAMPLER_TOP_DEFINES_SVH

// cond must hold at every edge out of reset
`define DLWR_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// same-cycle implication
`define DLWR_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DLWR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/dlwr_pkg.sv @@
// Types and constants for the diamond line warp resampler.
// No dependencies; used by the top level and the testbench.
package dlwr_pkg;

   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;

   localparam int DIM_W     = 10;  // image_width / image_height
   localparam int COORD_W   = 9;   // row / column fields
   localparam int CH_W      = 8;   // one color channel
   localparam int PIX_W     = 3 * CH_W;
   localparam int SPAN_W    = 11;  // span width, up to 512 at the default sizes
   localparam int K_W       = 12;  // signed offset into the span
   localparam int NUM_W     = 21;  // divider dividend
   localparam int QUO_W     = 11;  // divider quotient bits, one per step
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W     = 4;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register select on csr_paddr[2]
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 10'd500;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 10'd500;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_READ_A,
      ST_READ_B,
      ST_LATCH_B,
      ST_PUSH
   } state_type;

   // what the shared divider is working on
   typedef enum logic [1:0] {
      PH_POS,
      PH_RED,
      PH_GREEN,
      PH_BLUE
   } phase_type;

endpackage

@@ sv/dlwr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the source line for the resampler.
module dlwr_ram #(
   parameter int WIDTH  = 24,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/diamond_line_warp_resampler_top.sv @@
// Diamond line warp resampler, top level. Uses dlwr_pkg and dlwr_ram.
// req channel: tuser = op (0 load, 1 query); tdata = row, column, red, green, blue.
// A load writes one RGB pixel of the source line into the line store.
// A query returns one rsp: the pixel at (row, column) of the diamond-warped line,
// blended from the two nearest source pixels, or black with in_span 0 outside.
// A query inside the span keeps the block busy from accept until it is ready
// again: one 11-step shared restoring divider runs four times (source position,
// then red, green, blue), each pass after the ST_MUL state on the shared multiplier,
// plus the line store reads ST_READ_A, ST_READ_B, ST_LATCH_B through its single read port.
// A query outside the span goes from ST_CHECK straight to ST_PUSH. One request is in work at a time.
// The result sits in an output register, so the next request is taken while it
// waits; if the receiver still stalls when the next result is done, the block
// holds that result and stays busy. Reset clears the control state and sets
// image_width and image_height to 500; the line store is not cleared, so each
// source column must be loaded before it is queried. The user must write
// the registers over the csr port only while the block is idle; the block does not enforce it.
`include "diamond_line_warp_resampler_top_defines.svh"

module diamond_line_warp_resampler_top #(
   parameter int MAX_WIDTH  = dlwr_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = dlwr_pkg::MAX_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // row[8:0], column[17:9], red_in[25:18], green_in[33:26], blue_in[41:34], zero
   input  logic [dlwr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op[0]
   input  logic                              req_tuser,
   // response
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // red_out[7:0], green_out[15:8], blue_out[23:16]
   output logic [dlwr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // in_span[0]
   output logic                              rsp_tuser,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dlwr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dlwr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dlwr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam logic [31:0] MAXW32 = 32'(MAX_WIDTH);
   localparam logic [31:0] MAXH32 = 32'(MAX_HEIGHT);

   // csr
   logic [dlwr_pkg::DIM_W-1:0]   width_ff;
   logic [dlwr_pkg::DIM_W-1:0]   height_ff;
   logic                         csr_wr;

   // control
   dlwr_pkg::state_type          state_ff;
   dlwr_pkg::state_type          state_in;
   dlwr_pkg::phase_type          phase_ff;
   logic                         out_valid_ff;
   logic                         req_accept;
   logic                         push_go;

   // request fields
   logic                         req_op;
   logic [dlwr_pkg::COORD_W-1:0] req_row;
   logic [dlwr_pkg::COORD_W-1:0] req_col;
   logic [dlwr_pkg::PIX_W-1:0]   req_pix;

   // datapath
   logic [dlwr_pkg::COORD_W-1:0] row_ff;
   logic [dlwr_pkg::COORD_W-1:0] col_ff;
   logic [dlwr_pkg::SPAN_W-1:0]  w_ff;
   logic [dlwr_pkg::SPAN_W-1:0]  k_ff;
   logic [dlwr_pkg::SPAN_W-1:0]  rem_ff;
   logic [dlwr_pkg::QUO_W-1:0]   quo_ff;
   logic [dlwr_pkg::CNT_W-1:0]   cnt_ff;
   logic [dlwr_pkg::QUO_W-1:0]   f_ff;
   logic [dlwr_pkg::SPAN_W-1:0]  r_ff;
   logic [dlwr_pkg::PIX_W-1:0]   a_ff;
   logic [dlwr_pkg::PIX_W-1:0]   b_ff;
   logic                         span_ff;
   logic [dlwr_pkg::CH_W-1:0]    red_ff;
   logic [dlwr_pkg::CH_W-1:0]    green_ff;
   logic [dlwr_pkg::CH_W-1:0]    blue_ff;
   logic [dlwr_pkg::PIX_W-1:0]   out_pix_ff;
   logic                         out_span_ff;

   logic [dlwr_pkg::DIM_W-1:0]   sat_w;
   logic [dlwr_pkg::DIM_W-1:0]   sat_h;
   logic [dlwr_pkg::DIM_W-1:0]   h_m1;
   logic [dlwr_pkg::DIM_W-1:0]   mirror;
   logic [dlwr_pkg::DIM_W-1:0]   m_val;
   logic                         row_in_img;
   logic [dlwr_pkg::SPAN_W-1:0]  w_calc;
   logic signed [dlwr_pkg::K_W-1:0] k_calc;
   logic                         outside;

   logic [dlwr_pkg::CH_W-1:0]    a_ch;
   logic [dlwr_pkg::CH_W-1:0]    b_ch;
   logic [dlwr_pkg::NUM_W-1:0]   prod;

   logic [dlwr_pkg::SPAN_W:0]    trial;
   logic                         q_bit;
   logic [dlwr_pkg::SPAN_W-1:0]  rem_nx;
   logic [dlwr_pkg::QUO_W-1:0]   quo_nx;
   logic                         div_last;

   logic [dlwr_pkg::DIM_W-1:0]   w_last;
   logic [dlwr_pkg::QUO_W-1:0]   f1;
   logic [dlwr_pkg::DIM_W-1:0]   fa;
   logic [dlwr_pkg::DIM_W-1:0]   fb;

   logic                         ram_we;
   logic [AW-1:0]                ram_waddr;
   logic [AW-1:0]                ram_raddr;
   logic [dlwr_pkg::PIX_W-1:0]   ram_rdata;

   // ---------------------------------------------------------------- csr
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= dlwr_pkg::WIDTH_RESET;
         height_ff <= dlwr_pkg::HEIGHT_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            dlwr_pkg::REG_WIDTH:  width_ff  <= csr_pwdata[dlwr_pkg::DIM_W-1:0];
            dlwr_pkg::REG_HEIGHT: height_ff <= csr_pwdata[dlwr_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         dlwr_pkg::REG_WIDTH:  csr_prdata = {22'b0, width_ff};
         dlwr_pkg::REG_HEIGHT: csr_prdata = {22'b0, height_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- request
   assign req_op  = req_tuser;
   assign req_row = req_tdata[8:0];
   assign req_col = req_tdata[17:9];
   assign req_pix = {req_tdata[25:18], req_tdata[33:26], req_tdata[41:34]};

   assign req_accept = req_tvalid && req_tready;

   // loads go straight into the line store
   assign ram_we    = req_accept && (req_op == dlwr_pkg::OP_LOAD) &&
                      ({23'b0, req_col} < MAXW32);
   assign ram_waddr = AW'(req_col);

   dlwr_ram #(
      .WIDTH  (dlwr_pkg::PIX_W),
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (AW)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_pix),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------- geometry
   always_comb begin
      if (width_ff < 10'd2) begin
         sat_w = 10'd2;
      end else if ({22'b0, width_ff} > MAXW32) begin
         sat_w = dlwr_pkg::DIM_W'(MAX_WIDTH);
      end else begin
         sat_w = width_ff;
      end
      if (height_ff < 10'd2) begin
         sat_h = 10'd2;
      end else if ({22'b0, height_ff} > MAXH32) begin
         sat_h = dlwr_pkg::DIM_W'(MAX_HEIGHT);
      end else begin
         sat_h = height_ff;
      end
   end

   assign row_in_img = {1'b0, row_ff} < sat_h;
   assign h_m1       = sat_h - 10'd1;
   assign mirror     = h_m1 - {1'b0, row_ff};
   assign m_val      = ({1'b0, row_ff} < mirror) ? {1'b0, row_ff} : mirror;
   assign w_calc     = {m_val, 1'b0} + 11'd2;
   // k = column - (W/2 - w/2 - 1), with w/2 = m + 1
   assign k_calc     = $signed({3'b0, col_ff}) - $signed({3'b0, sat_w[9:1]}) +
                       $signed({2'b0, m_val}) + 12'sd2;
   assign outside    = !row_in_img ||
                       (col_ff >= sat_w[8:0] && sat_w[9] == 1'b0) ||
                       k_calc[dlwr_pkg::K_W-1] ||
                       (k_calc > $signed({1'b0, w_calc}));

   // ---------------------------------------------------------------- shared multiplier
   always_comb begin
      case (phase_ff)
         dlwr_pkg::PH_RED: begin
            a_ch = a_ff[23:16];
            b_ch = b_ff[23:16];
         end
         dlwr_pkg::PH_GREEN: begin
            a_ch = a_ff[15:8];
            b_ch = b_ff[15:8];
         end
         dlwr_pkg::PH_BLUE: begin
            a_ch = a_ff[7:0];
            b_ch = b_ff[7:0];
         end
         default: begin
            a_ch = '0;
            b_ch = '0;
         end
      endcase
      if (phase_ff == dlwr_pkg::PH_POS) begin
         prod = dlwr_pkg::NUM_W'(k_ff) * dlwr_pkg::NUM_W'(sat_w);
      end else begin
         prod = dlwr_pkg::NUM_W'(a_ch) * dlwr_pkg::NUM_W'(w_ff - r_ff) +
                dlwr_pkg::NUM_W'(b_ch) * dlwr_pkg::NUM_W'(r_ff);
      end
   end

   // ---------------------------------------------------------------- shared divider
   // dividend < w * 2^11, so the top bits start below w and 11 steps suffice
   assign trial    = {rem_ff, quo_ff[dlwr_pkg::QUO_W-1]};
   assign q_bit    = trial >= {1'b0, w_ff};
   assign rem_nx   = q_bit ? dlwr_pkg::SPAN_W'(trial - {1'b0, w_ff})
                           : trial[dlwr_pkg::SPAN_W-1:0];
   assign quo_nx   = {quo_ff[dlwr_pkg::QUO_W-2:0], q_bit};
   assign div_last = cnt_ff == dlwr_pkg::CNT_W'(dlwr_pkg::DIV_STEPS - 1);

   // neighbor indices clamped to W-1
   assign w_last = sat_w - 10'd1;
   assign f1     = f_ff + 11'd1;
   assign fa     = (f_ff > {1'b0, w_last}) ? w_last : f_ff[dlwr_pkg::DIM_W-1:0];
   assign fb     = (f1 > {1'b0, w_last}) ? w_last : f1[dlwr_pkg::DIM_W-1:0];

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dlwr_pkg::ST_IDLE: begin
            if (req_accept && req_op == dlwr_pkg::OP_QUERY) begin
               state_in = dlwr_pkg::ST_CHECK;
            end
         end
         dlwr_pkg::ST_CHECK: begin
            state_in = outside ? dlwr_pkg::ST_PUSH : dlwr_pkg::ST_MUL;
         end
         dlwr_pkg::ST_MUL: state_in = dlwr_pkg::ST_DIV;
         dlwr_pkg::ST_DIV: begin
            if (div_last) begin
               if (phase_ff == dlwr_pkg::PH_POS) begin
                  state_in = dlwr_pkg::ST_READ_A;
               end else if (phase_ff == dlwr_pkg::PH_BLUE) begin
                  state_in = dlwr_pkg::ST_PUSH;
               end else begin
                  state_in = dlwr_pkg::ST_MUL;
               end
            end
         end
         dlwr_pkg::ST_READ_A:  state_in = dlwr_pkg::ST_READ_B;
         dlwr_pkg::ST_READ_B:  state_in = dlwr_pkg::ST_LATCH_B;
         dlwr_pkg::ST_LATCH_B: state_in = dlwr_pkg::ST_MUL;
         dlwr_pkg::ST_PUSH: begin
            if (push_go) begin
               state_in = dlwr_pkg::ST_IDLE;
            end
         end
         default: state_in = dlwr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = state_ff == dlwr_pkg::ST_IDLE;
      push_go    = (state_ff == dlwr_pkg::ST_PUSH) && (!out_valid_ff || rsp_tready);
      ram_raddr  = (state_ff == dlwr_pkg::ST_READ_A) ? AW'(fa) : AW'(fb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlwr_pkg::ST_IDLE;
         phase_ff     <= dlwr_pkg::PH_POS;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            phase_ff <= dlwr_pkg::PH_POS;
         end else if (state_ff == dlwr_pkg::ST_DIV && div_last &&
                      phase_ff != dlwr_pkg::PH_BLUE) begin
            phase_ff <= dlwr_pkg::phase_type'(phase_ff + 2'd1);
         end
         if (push_go) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (req_accept) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
      case (state_ff)
         dlwr_pkg::ST_CHECK: begin
            w_ff     <= w_calc;
            k_ff     <= k_calc[dlwr_pkg::SPAN_W-1:0];
            span_ff  <= !outside;
            red_ff   <= '0;
            green_ff <= '0;
            blue_ff  <= '0;
         end
         dlwr_pkg::ST_MUL: begin
            rem_ff <= {1'b0, prod[dlwr_pkg::NUM_W-1:dlwr_pkg::QUO_W]};
            quo_ff <= prod[dlwr_pkg::QUO_W-1:0];
            cnt_ff <= '0;
         end
         dlwr_pkg::ST_DIV: begin
            rem_ff <= rem_nx;
            quo_ff <= quo_nx;
            cnt_ff <= cnt_ff + 4'd1;
            if (div_last) begin
               case (phase_ff)
                  dlwr_pkg::PH_POS: begin
                     f_ff <= quo_nx;
                     r_ff <= rem_nx;
                  end
                  dlwr_pkg::PH_RED:   red_ff   <= quo_nx[dlwr_pkg::CH_W-1:0];
                  dlwr_pkg::PH_GREEN: green_ff <= quo_nx[dlwr_pkg::CH_W-1:0];
                  default:            blue_ff  <= quo_nx[dlwr_pkg::CH_W-1:0];
               endcase
            end
         end
         dlwr_pkg::ST_READ_B:  a_ff <= ram_rdata;
         dlwr_pkg::ST_LATCH_B: b_ff <= ram_rdata;
         default: ;
      endcase
      if (push_go) begin
         out_pix_ff  <= {blue_ff, green_ff, red_ff};
         out_span_ff <= span_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tuser  = out_span_ff;

   // ---------------------------------------------------------------- checks
   `DLWR_ASSERT_IMPLIES(a_div_rem_below_span, state_ff == dlwr_pkg::ST_DIV, rem_ff < w_ff, "divider remainder reached span width")
   `DLWR_ASSERT_NEXT(a_load_single_cycle, req_accept && req_op == dlwr_pkg::OP_LOAD, state_ff == dlwr_pkg::ST_IDLE, "load left the sequencer busy")
   `DLWR_ASSERT_IMPLIES(a_pos_within_width, state_ff == dlwr_pkg::ST_READ_A, f_ff <= {1'b0, sat_w}, "source position beyond image width")
   `DLWR_ASSERT_HOLDS(a_outside_is_black, !(out_valid_ff && !out_span_ff) || out_pix_ff == '0, "result outside span is not black")

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for diamond_line_warp_resampler_top: pixel loads and warp queries
// driven over the req stream, results predicted in place and compared on the rsp stream.
// Depends on dlwr_pkg and the top level RTL only.
module tb_top;

   localparam int    LINE_DEPTH     = 512;
   localparam int    SETTLE_CYCLES  = 64;
   localparam int    QUIET_LIMIT    = 4000;  // cycles with no handshake at all
   localparam int    PHASE_REQS     = 28;

   typedef struct {
      logic            op;
      logic [8:0]      row;
      logic [8:0]      column;
      logic [7:0]      red;
      logic [7:0]      green;
      logic [7:0]      blue;
   } warp_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       in_span;
   } warp_pixel_type;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [dlwr_pkg::REQ_DATA_W-1:0]     req_tdata;
   logic                                req_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [dlwr_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic                                rsp_tuser;
   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [dlwr_pkg::CSR_ADDR_W-1:0]     csr_paddr;
   logic [dlwr_pkg::CSR_DATA_W-1:0]     csr_pwdata;
   logic [dlwr_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                csr_pready;

   // predictor state
   logic [dlwr_pkg::PIX_W-1:0]          line_copy [LINE_DEPTH];
   logic [dlwr_pkg::DIM_W-1:0]          cfg_width;
   logic [dlwr_pkg::DIM_W-1:0]          cfg_height;

   warp_req_type            pending_reqs [$];
   warp_pixel_type          expected_pixels [$];
   warp_req_type            next_req;
   warp_pixel_type          got_pixel;
   warp_pixel_type          want_pixel;
   logic                    req_taken;
   logic [8:0]              seen_row;
   logic [8:0]              seen_col;
   int unsigned             send_idle_pct;
   int unsigned             recv_stall_pct;
   int unsigned             quiet_cycles;
   int unsigned             mismatch_count;
   logic                    any_handshake;

   diamond_line_warp_resampler_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic int unsigned eff_dim(logic [dlwr_pkg::DIM_W-1:0] v, int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return 32'(v);
   endfunction

   function automatic logic [7:0] blend_channel(logic [7:0] a, logic [7:0] b,
                                                int unsigned frac, int unsigned span_w);
      return 8'((32'(a) * (span_w - frac) + 32'(b) * frac) / span_w);
   endfunction

   // output pixel of the diamond warp at (row, col) under the current line and size
   function automatic warp_pixel_type warp_lookup(logic [8:0] row, logic [8:0] col);
      int unsigned img_w, img_h, half, span_w, num, frac, f_lo, f_hi;
      int          span_start, k_off;
      logic [23:0] a, b;
      warp_pixel_type px;
      px = '0;
      img_w = eff_dim(cfg_width, dlwr_pkg::MAX_WIDTH_DEF);
      img_h = eff_dim(cfg_height, dlwr_pkg::MAX_HEIGHT_DEF);
      if (row >= img_h || col >= img_w) return px;
      // lower half mirrors the upper half
      half = (row < img_h - 1 - row) ? 32'(row) : img_h - 1 - 32'(row);
      span_w = 2 + 2 * half;
      span_start = int'(img_w / 2) - int'(span_w / 2) - 1;
      k_off = int'(col) - span_start;
      if (k_off < 0 || k_off > int'(span_w)) return px;
      num = int'(k_off) * img_w;
      f_lo = num / span_w;
      frac = num % span_w;
      f_hi = f_lo + 1;
      if (f_lo > img_w - 1) f_lo = img_w - 1;
      if (f_hi > img_w - 1) f_hi = img_w - 1;
      a = line_copy[f_lo];
      b = line_copy[f_hi];
      px.red     = blend_channel(a[23:16], b[23:16], frac, span_w);
      px.green   = blend_channel(a[15:8], b[15:8], frac, span_w);
      px.blue    = blend_channel(a[7:0], b[7:0], frac, span_w);
      px.in_span = 1'b1;
      return px;
   endfunction

   function automatic logic [7:0] rand_channel();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic queue_load(int col, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      warp_req_type it;
      it.op = dlwr_pkg::OP_LOAD;
      it.row = 9'($urandom);
      it.column = 9'(col);
      it.red = r;
      it.green = g;
      it.blue = b;
      pending_reqs.push_back(it);
   endtask

   task automatic queue_query(int row, int col);
      warp_req_type it;
      it.op = dlwr_pkg::OP_QUERY;
      it.row = 9'(row);
      it.column = 9'(col);
      it.red = rand_channel();
      it.green = rand_channel();
      it.blue = rand_channel();
      pending_reqs.push_back(it);
   endtask

   task automatic queue_random_mix(int n);
      int unsigned img_w, img_h, half, span_w, row;
      int          span_start, cand;
      for (int i = 0; i < n; i++) begin
         img_w = eff_dim(cfg_width, dlwr_pkg::MAX_WIDTH_DEF);
         img_h = eff_dim(cfg_height, dlwr_pkg::MAX_HEIGHT_DEF);
         if ($urandom_range(0, 99) < 30) begin
            cand = $urandom_range(0, 1) ? $urandom_range(0, img_w - 1) : $urandom_range(0, 511);
            queue_load(cand, rand_channel(), rand_channel(), rand_channel());
         end else begin
            row = ($urandom_range(0, 9) != 0) ? $urandom_range(0, img_h - 1)
                                               : $urandom_range(0, 511);
            cand = $urandom_range(0, 511);
            // aim most queries at the row's span, edges included
            if (row < img_h && $urandom_range(0, 3) != 0) begin
               half = (row < img_h - 1 - row) ? row : img_h - 1 - row;
               span_w = 2 + 2 * half;
               span_start = int'(img_w / 2) - int'(span_w / 2) - 1;
               case ($urandom_range(0, 5))
                  0: cand = span_start;
                  1: cand = span_start + int'(span_w);
                  default: cand = span_start + int'($urandom_range(0, span_w));
               endcase
               if (cand < 0 || cand > 511) cand = $urandom_range(0, 511);
            end
            queue_query(row, cand);
         end
      end
   endtask

   task automatic csr_write(logic sel, logic [dlwr_pkg::DIM_W-1:0] value);
      logic [dlwr_pkg::CSR_DATA_W-dlwr_pkg::DIM_W-1:0] upper;
      upper = ($urandom_range(0, 1)) ? '0
                                     : (dlwr_pkg::CSR_DATA_W-dlwr_pkg::DIM_W)'($urandom);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= {upper, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      // register reads back what was written
      if (csr_prdata !== {{(dlwr_pkg::CSR_DATA_W-dlwr_pkg::DIM_W){1'b0}}, value}) begin
         mismatch_count++;
         $error("csr_prdata: expected %0d, got %0d", value, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_req = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_req.op;
            req_tdata  <= {6'b0, next_req.blue, next_req.green, next_req.red,
                           next_req.column, next_req.row};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         any_handshake = 1'b0;
         if (rsp_tvalid && rsp_tready) begin
            any_handshake = 1'b1;
            got_pixel = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tuser};
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               $error("result with no query waiting: red_out %0d green_out %0d %s %0d %s %0d",
                      got_pixel.red, got_pixel.green, "blue_out", got_pixel.blue,
                      "in_span", got_pixel.in_span);
            end else begin
               want_pixel = expected_pixels.pop_front();
               if (got_pixel.red !== want_pixel.red) begin
                  mismatch_count++;
                  $error("red_out: expected %0d, got %0d", want_pixel.red, got_pixel.red);
               end
               if (got_pixel.green !== want_pixel.green) begin
                  mismatch_count++;
                  $error("green_out: expected %0d, got %0d", want_pixel.green, got_pixel.green);
               end
               if (got_pixel.blue !== want_pixel.blue) begin
                  mismatch_count++;
                  $error("blue_out: expected %0d, got %0d", want_pixel.blue, got_pixel.blue);
               end
               if (got_pixel.in_span !== want_pixel.in_span) begin
                  mismatch_count++;
                  $error("in_span: expected %0d, got %0d", want_pixel.in_span,
                         got_pixel.in_span);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            any_handshake = 1'b1;
            req_taken = 1'b1;
            seen_row = req_tdata[8:0];
            seen_col = req_tdata[17:9];
            if (req_tuser == dlwr_pkg::OP_LOAD)
               line_copy[seen_col] = {req_tdata[25:18], req_tdata[33:26], req_tdata[41:34]};
            else
               expected_pixels.push_back(warp_lookup(seen_row, seen_col));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            any_handshake = 1'b1;
            if (csr_paddr[2] == dlwr_pkg::REG_WIDTH)
               cfg_width = csr_pwdata[dlwr_pkg::DIM_W-1:0];
            else
               cfg_height = csr_pwdata[dlwr_pkg::DIM_W-1:0];
         end
         quiet_cycles = any_handshake ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int unsigned cfg_w_list [8];
      int unsigned cfg_h_list [8];
      cfg_w_list = '{512, 2, 2, 512, 0, 1023, 37, 500};
      cfg_h_list = '{512, 2, 512, 2, 1, 1023, 301, 257};
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = dlwr_pkg::OP_LOAD;
      rsp_tready     = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      req_taken      = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      cfg_width      = dlwr_pkg::WIDTH_RESET;
      cfg_height     = dlwr_pkg::HEIGHT_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // whole line store loaded first, so no query can read an unwritten entry
      for (int c = 0; c < LINE_DEPTH; c++)
         queue_load(c, rand_channel(), rand_channel(), rand_channel());

      // directed, reset size 500x500: span of row 0 is columns 248..250
      queue_load(0, 8'hFF, 8'hFF, 8'hFF);
      queue_load(1, 8'h00, 8'h00, 8'h00);
      queue_load(499, 8'hFF, 8'h00, 8'hFF);
      queue_load(511, 8'h00, 8'hFF, 8'h00);
      queue_query(0, 247);
      queue_query(0, 248);
      queue_query(0, 249);
      queue_query(0, 250);
      queue_query(0, 251);
      queue_query(499, 249);    // mirrored bottom row
      queue_query(249, 0);      // widest row, span starts left of column 0
      queue_query(250, 0);
      queue_query(249, 498);
      queue_query(249, 499);    // far span edge, neighbor clamped
      queue_query(500, 250);    // row past the image
      queue_query(511, 511);
      queue_query(100, 511);    // column past the image
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         if (p == 6) begin
            cfg_w_list[p] = $urandom_range(2, 512);
            cfg_h_list[p] = $urandom_range(2, 512);
         end
         csr_write(dlwr_pkg::REG_WIDTH, dlwr_pkg::DIM_W'(cfg_w_list[p]));
         csr_write(dlwr_pkg::REG_HEIGHT, dlwr_pkg::DIM_W'(cfg_h_list[p]));
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         queue_random_mix(PHASE_REQS);
         wait_drained();
      end

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
